### rtl/rrl_pkg.sv
// Shared types and constants for the report rate-limit table.
// Holds the transaction payload structs, command codes and register indexes.
// No dependencies.
package rrl_pkg;

    localparam int IDENT_W   = 64;
    localparam int NOW_W     = 32;
    localparam int CMD_W     = 3;
    localparam int COUNT_W   = 5;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POLL   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ALL    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_COLLECTION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 1'b1;

    localparam logic [CFG_W-1:0] COLLECTION_RESET = 32'd1000;
    localparam logic [CFG_W-1:0] TOLERANCE_RESET  = 32'd1000;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [IDENT_W-1:0] ident;
        logic [NOW_W-1:0]   now;
    } t_in_item;

    typedef struct packed {
        logic [IDENT_W-1:0] out_ident;
        logic               flag;
        logic               dropped;
        logic               last_of_run;
        logic [COUNT_W-1:0] entry_count;
    } t_out_item;

endpackage

### rtl/rrl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read data holds its value while no read is issued. No dependencies.
module rrl_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_W-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0]     i_wr_data,
    input  logic                 i_rd_en,
    input  logic [ADDR_W-1:0]    i_rd_addr,
    output logic [WIDTH-1:0]     o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/rrl_age_unit.sv
// Shared age comparator: wrap-safe age of a stamp against a threshold.
// Used by the sequencer for both expiry and report checks. No dependencies.
module rrl_age_unit #(
    parameter int TIME_BITS = 32
) (
    input  logic [TIME_BITS-1:0] i_now,
    input  logic [TIME_BITS-1:0] i_stamp,
    input  logic [TIME_BITS-1:0] i_limit,
    output logic                 o_over
);
    logic [TIME_BITS-1:0] age;

    // modulo 2^TIME_BITS difference
    assign age    = i_now - i_stamp;
    assign o_over = (age > i_limit);

endmodule

### rtl/report_rate_limit_table.sv
// Top level of the report rate-limit table: sequencer, entry memory, config registers.
// Depends on rrl_pkg, rrl_ram and rrl_age_unit.
//
// The table keeps up to TABLE_DEPTH identifiers packed at the front of one entry
// memory, each with a last-report and a last-seen stamp of TIME_BITS ticks. One
// transaction is taken at a time: the input stalls from acceptance until the
// walk over the memory has ended and the last result of that transaction has
// been staged into the output register. Every operation walks the memory
// through its single read port, issuing one read and then evaluating the
// entry, so the cost scales with the fill count N: add, query and remove scan
// the entries up to the match, remove then shifts every entry behind the
// removed one down, report-all visits every entry, and poll makes a counting
// pass (it must know the final count and the last due entry before emitting)
// followed by an emit-and-compact pass. The single age comparator is
// time-shared between the expiry check (last-seen against collection plus
// tolerance, saturated) and the report check (last-report against collection),
// and each poll entry is checked by both in turn, S_EV then S_EV2. Each result
// waits in the output register until taken; a stalled output holds the
// sequencer. Config registers may be written only while the block is idle.
module report_rate_limit_table #(
    parameter int TABLE_DEPTH = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input transactions
    input  logic                           i_in_valid,
    input  rrl_pkg::t_in_item              i_in_data,
    output logic                           o_in_stall,
    // result transactions
    output logic                           o_out_valid,
    output rrl_pkg::t_out_item             o_out_data,
    input  logic                           i_out_stall,
    // config writes
    input  logic                           i_cfg_valid,
    input  logic [rrl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rrl_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                           o_cfg_ready
);
    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = rrl_pkg::IDENT_W + 2 * TIME_BITS;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EV,
        S_EV2,
        S_OUT
    } t_state;

    // what the current walk over the memory is doing
    typedef enum logic [2:0] {
        P_FIND,
        P_SHIFT,
        P_COUNT,
        P_APPLY,
        P_ALL
    } t_pass;

    // ---------------------------------------------------------------- config
    logic [TIME_BITS-1:0] r_coll;
    logic [TIME_BITS-1:0] r_tol;
    logic [TIME_BITS:0]   lim_sum;
    logic [TIME_BITS-1:0] limit_sat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coll <= TIME_BITS'(rrl_pkg::COLLECTION_RESET);
            r_tol  <= TIME_BITS'(rrl_pkg::TOLERANCE_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rrl_pkg::CFG_COLLECTION: r_coll <= TIME_BITS'(i_cfg_data);
                rrl_pkg::CFG_TOLERANCE:  r_tol  <= TIME_BITS'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // expiry threshold: collection plus tolerance, saturated
    assign lim_sum   = {1'b0, r_coll} + {1'b0, r_tol};
    assign limit_sat = lim_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : lim_sum[TIME_BITS-1:0];

    // ---------------------------------------------------------------- state
    t_state               r_state, n_state;
    t_state               r_after, n_after;
    t_pass                r_pass, n_pass;
    logic [rrl_pkg::CMD_W-1:0]   r_cmd, n_cmd;
    logic [rrl_pkg::IDENT_W-1:0] r_ident, n_ident;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [TIME_BITS-1:0] r_limit, n_limit;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic [CNT_W-1:0]     r_w, n_w;
    logic [CNT_W-1:0]     r_keep, n_keep;
    logic [CNT_W-1:0]     r_nemit, n_nemit;
    logic [CNT_W-1:0]     r_emitted, n_emitted;
    logic [CNT_W-1:0]     r_fill, n_fill;
    logic                 r_exp, n_exp;
    rrl_pkg::t_out_item   r_res, n_res;
    logic                 r_out_valid, n_out_valid;
    rrl_pkg::t_out_item   r_out_data, n_out_data;

    // ---------------------------------------------------------------- memory
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic                 ram_re;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [rrl_pkg::IDENT_W-1:0] rd_ident;
    logic [TIME_BITS-1:0] rd_rpt;
    logic [TIME_BITS-1:0] rd_seen;

    assign rd_ident = ram_rdata[ENTRY_W-1 -: rrl_pkg::IDENT_W];
    assign rd_rpt   = ram_rdata[2*TIME_BITS-1 -: TIME_BITS];
    assign rd_seen  = ram_rdata[TIME_BITS-1:0];

    rrl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entries (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (ram_rdata)
    );

    // ---------------------------------------------------------------- age unit
    // first evaluation cycle checks expiry, second checks report due
    logic [TIME_BITS-1:0] unit_stamp;
    logic [TIME_BITS-1:0] unit_limit;
    logic                 age_over;

    assign unit_stamp = (r_state == S_EV) ? rd_seen : rd_rpt;
    assign unit_limit = (r_state == S_EV) ? r_limit : r_coll;

    rrl_age_unit #(
        .TIME_BITS (TIME_BITS)
    ) u_age (
        .i_now   (r_now),
        .i_stamp (unit_stamp),
        .i_limit (unit_limit),
        .o_over  (age_over)
    );

    // ---------------------------------------------------------------- sequencer
    logic in_acc;
    logic slot_free;
    logic [CNT_W-1:0] fill_inc;
    logic [CNT_W-1:0] fill_dec;
    logic [CNT_W-1:0] idx_dec;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign fill_inc   = r_fill + ONE_C;
    assign fill_dec   = r_fill - ONE_C;
    assign idx_dec    = r_idx - ONE_C;

    always_comb begin
        n_state     = r_state;
        n_after     = r_after;
        n_pass      = r_pass;
        n_cmd       = r_cmd;
        n_ident     = r_ident;
        n_now       = r_now;
        n_limit     = r_limit;
        n_idx       = r_idx;
        n_w         = r_w;
        n_keep      = r_keep;
        n_nemit     = r_nemit;
        n_emitted   = r_emitted;
        n_fill      = r_fill;
        n_exp       = r_exp;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_waddr   = r_idx[IDX_W-1:0];
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;

        // drain the output register when its transaction completes
        if (slot_free) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd     = i_in_data.cmd;
                    n_ident   = i_in_data.ident;
                    n_now     = TIME_BITS'(i_in_data.now);
                    n_limit   = limit_sat;
                    n_idx     = '0;
                    n_w       = '0;
                    n_keep    = '0;
                    n_nemit   = '0;
                    n_emitted = '0;
                    n_res     = '0;
                    n_res.last_of_run = 1'b1;
                    n_res.entry_count = rrl_pkg::COUNT_W'(r_fill);
                    n_after   = S_IDLE;
                    case (i_in_data.cmd)
                        rrl_pkg::CMD_ADD, rrl_pkg::CMD_QUERY, rrl_pkg::CMD_REMOVE: begin
                            n_pass  = P_FIND;
                            n_state = S_RD;
                        end
                        rrl_pkg::CMD_POLL: begin
                            n_pass  = P_COUNT;
                            n_state = S_RD;
                        end
                        rrl_pkg::CMD_ALL: begin
                            n_pass  = P_ALL;
                            n_nemit = r_fill;
                            n_state = S_RD;
                        end
                        default: begin
                            // unknown command: one empty result, no state change
                            n_state = S_OUT;
                        end
                    endcase
                end
            end

            S_RD: begin
                if (r_idx < r_fill) begin
                    ram_re  = 1'b1;
                    n_state = S_EV;
                end else begin
                    // end of the current walk
                    n_res             = '0;
                    n_res.last_of_run = 1'b1;
                    n_res.entry_count = rrl_pkg::COUNT_W'(r_fill);
                    n_after           = S_IDLE;
                    case (r_pass)
                        P_FIND: begin
                            n_state = S_OUT;
                            if (r_cmd == rrl_pkg::CMD_ADD) begin
                                n_res.flag = 1'b1;
                                if (r_fill < DEPTH_C) begin
                                    // append the new identifier
                                    ram_we    = 1'b1;
                                    ram_waddr = r_fill[IDX_W-1:0];
                                    ram_wdata = {r_ident, r_now, r_now};
                                    n_fill    = fill_inc;
                                    n_res.entry_count = rrl_pkg::COUNT_W'(fill_inc);
                                end else begin
                                    n_res.dropped = 1'b1;
                                end
                            end
                        end
                        P_SHIFT: begin
                            n_fill            = fill_dec;
                            n_res.flag        = 1'b1;
                            n_res.entry_count = rrl_pkg::COUNT_W'(fill_dec);
                            n_state           = S_OUT;
                        end
                        P_COUNT: begin
                            n_pass = P_APPLY;
                            n_idx  = '0;
                        end
                        P_APPLY: begin
                            n_fill            = r_w;
                            n_res.entry_count = rrl_pkg::COUNT_W'(r_w);
                            n_state           = (r_nemit == '0) ? S_OUT : S_IDLE;
                        end
                        P_ALL: begin
                            n_state = (r_fill == '0) ? S_OUT : S_IDLE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_EV: begin
                n_res             = '0;
                n_res.entry_count = rrl_pkg::COUNT_W'(r_fill);
                case (r_pass)
                    P_FIND: begin
                        if (rd_ident == r_ident) begin
                            n_res.last_of_run = 1'b1;
                            n_after           = S_IDLE;
                            case (r_cmd)
                                rrl_pkg::CMD_ADD: begin
                                    // known identifier: refresh last-seen only
                                    ram_we    = 1'b1;
                                    ram_wdata = {rd_ident, rd_rpt, r_now};
                                    n_state   = S_OUT;
                                end
                                rrl_pkg::CMD_REMOVE: begin
                                    n_pass  = P_SHIFT;
                                    n_idx   = r_idx + ONE_C;
                                    n_state = S_RD;
                                end
                                default: begin
                                    n_res.flag = 1'b1;
                                    n_state    = S_OUT;
                                end
                            endcase
                        end else begin
                            n_idx   = r_idx + ONE_C;
                            n_state = S_RD;
                        end
                    end
                    P_SHIFT: begin
                        // close the gap, one entry down
                        ram_we    = 1'b1;
                        ram_waddr = idx_dec[IDX_W-1:0];
                        n_idx     = r_idx + ONE_C;
                        n_state   = S_RD;
                    end
                    P_COUNT: begin
                        if (!age_over) begin
                            n_keep = r_keep + ONE_C;
                        end
                        n_state = S_EV2;
                    end
                    P_APPLY: begin
                        n_exp   = age_over;
                        n_state = S_EV2;
                    end
                    P_ALL: begin
                        ram_we            = 1'b1;
                        ram_wdata         = {rd_ident, r_now, rd_seen};
                        n_res.out_ident   = rd_ident;
                        n_res.flag        = 1'b1;
                        n_res.last_of_run = (fill_dec == r_idx);
                        n_idx             = r_idx + ONE_C;
                        n_after           = S_RD;
                        n_state           = S_OUT;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_EV2: begin
                n_idx   = r_idx + ONE_C;
                n_state = S_RD;
                case (r_pass)
                    P_COUNT: begin
                        if (age_over) begin
                            n_nemit = r_nemit + ONE_C;
                        end
                    end
                    P_APPLY: begin
                        // keep unexpired entries, packed at the write pointer
                        if (!r_exp) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_w[IDX_W-1:0];
                            ram_wdata = {rd_ident, (age_over ? r_now : rd_rpt), rd_seen};
                            n_w       = r_w + ONE_C;
                        end
                        if (age_over) begin
                            n_res             = '0;
                            n_res.out_ident   = rd_ident;
                            n_res.flag        = 1'b1;
                            n_res.last_of_run = ((r_emitted + ONE_C) == r_nemit);
                            n_res.entry_count = rrl_pkg::COUNT_W'(r_keep);
                            n_emitted         = r_emitted + ONE_C;
                            n_after           = S_RD;
                            n_state           = S_OUT;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_OUT: begin
                // hold until the output register frees up
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = r_after;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= S_IDLE;
            r_pass      <= P_FIND;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_after     <= n_after;
            r_pass      <= n_pass;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_ident    <= n_ident;
        r_now      <= n_now;
        r_limit    <= n_limit;
        r_idx      <= n_idx;
        r_w        <= n_w;
        r_keep     <= n_keep;
        r_nemit    <= n_nemit;
        r_emitted  <= n_emitted;
        r_exp      <= n_exp;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
